/* design/cau_pkg.sv */
// Shared constants and command codes of the complex arithmetic unit.
package cau_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_WORD_BITS = 32;
    localparam int IO_BITS       = 32;
    localparam int CMD_BITS      = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CMP = 3'd4
    } t_cmd;

endpackage

/* design/complex_arithmetic_unit.sv */
// Each request passes through the front stages, the divider cells and the output register, in that order.
// Throughput: one request per cycle while no stall holds the row; the divider is a row of WORD_BITS cells, one
// quotient bit each, and every stage moves on as soon as the stage after it frees up.
// A stalled result sits in the output register while bubbles ahead of it still fill.
// Reset is synchronous and active low; it clears only the valid bits of the stages.
// There is no configuration and no state that lasts from one request to the next.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS,
    parameter int WORD_BITS = cau_pkg::DEF_WORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [cau_pkg::CMD_BITS-1:0]       i_cmd,
    input  logic signed [cau_pkg::IO_BITS-1:0] i_lhs_re,
    input  logic signed [cau_pkg::IO_BITS-1:0] i_lhs_im,
    input  logic signed [cau_pkg::IO_BITS-1:0] i_rhs_re,
    input  logic signed [cau_pkg::IO_BITS-1:0] i_rhs_im,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [cau_pkg::IO_BITS-1:0] o_res_re,
    output logic signed [cau_pkg::IO_BITS-1:0] o_res_im,
    output logic                               o_div_zero,
    output logic                               o_equal,
    output logic                               o_saturated
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int P  = 2 * W;
    localparam int SW = 8 + 2 * W;
    // The remainder must hold a product magnitude scaled up by the fraction bits and
    // the divisor scaled up by a whole word, whichever is wider.
    localparam int NB = P + 2 + ((FRAC_BITS > W) ? FRAC_BITS : W);

    // Chain links: index i feeds cell i, index W is the output of the last cell.
    logic          ch_v   [W+1];
    logic          ch_rdy [W+1];
    logic [SW-1:0] ch_side[W+1];
    logic [NB-1:0] ch_rre [W+1];
    logic [NB-1:0] ch_rim [W+1];
    logic [P-1:0]  ch_den [W+1];
    logic [W-1:0]  ch_qre [W+1];
    logic [W-1:0]  ch_qim [W+1];

    cau_prep #(
        .FRAC_BITS(FRAC_BITS),
        .WORD_BITS(WORD_BITS),
        .SW(SW),
        .NB(NB)
    ) u_prep (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd(i_cmd),
        .i_lhs_re(i_lhs_re),
        .i_lhs_im(i_lhs_im),
        .i_rhs_re(i_rhs_re),
        .i_rhs_im(i_rhs_im),
        .o_valid(ch_v[0]),
        .i_ready(ch_rdy[0]),
        .o_side(ch_side[0]),
        .o_rem_re(ch_rre[0]),
        .o_rem_im(ch_rim[0]),
        .o_den(ch_den[0])
    );

    // The quotient starts empty; each cell ORs in its own bit, most significant first.
    assign ch_qre[0] = '0;
    assign ch_qim[0] = '0;

    for (genvar i = 0; i < W; i++) begin : g_cell
        cau_cell #(
            .WORD_BITS(WORD_BITS),
            .BIT(W - 1 - i),
            .SW(SW),
            .NB(NB)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(ch_v[i]),
            .o_ready(ch_rdy[i]),
            .i_side(ch_side[i]),
            .i_rem_re(ch_rre[i]),
            .i_rem_im(ch_rim[i]),
            .i_den(ch_den[i]),
            .i_q_re(ch_qre[i]),
            .i_q_im(ch_qim[i]),
            .o_valid(ch_v[i+1]),
            .i_ready(ch_rdy[i+1]),
            .o_side(ch_side[i+1]),
            .o_rem_re(ch_rre[i+1]),
            .o_rem_im(ch_rim[i+1]),
            .o_den(ch_den[i+1]),
            .o_q_re(ch_qre[i+1]),
            .o_q_im(ch_qim[i+1])
        );
    end

    // Clips a quotient magnitude to the word range; returns {saturated, value}.
    function automatic logic [W:0] clip_q(input logic neg, input logic ovf,
                                          input logic [W-1:0] q);
        logic [W:0] mag;
        logic [W:0] maxneg;
        logic [W:0] res;
        mag = {1'b0, q};
        maxneg = (W+1)'(1) << (W - 1);
        if (neg) begin
            if (ovf || mag > maxneg) begin
                res = {1'b1, 1'b1, {(W-1){1'b0}}};
            end else begin
                res = {1'b0, W'(-mag)};
            end
        end else begin
            if (ovf || mag > maxneg - (W+1)'(1)) begin
                res = {1'b1, 1'b0, {(W-1){1'b1}}};
            end else begin
                res = {1'b0, mag[W-1:0]};
            end
        end
        return res;
    endfunction

    // Side-band fields carried down the row with each request.
    logic is_div, dz, eq, sat, neg_re, neg_im, ovf_re, ovf_im;
    logic [W-1:0] side_re, side_im;
    logic [W:0] cl_re, cl_im;
    logic n_dz, n_eq, n_sat;
    logic [W-1:0] n_re, n_im;

    assign {is_div, dz, eq, sat, neg_re, neg_im, ovf_re, ovf_im, side_re, side_im}
        = ch_side[W];

    always_comb begin
        cl_re = clip_q(neg_re, ovf_re, ch_qre[W]);
        cl_im = clip_q(neg_im, ovf_im, ch_qim[W]);
        n_dz  = dz;
        n_eq  = eq;
        if (!is_div) begin
            n_sat = sat;
            n_re  = side_re;
            n_im  = side_im;
        end else if (dz) begin
            n_sat = 1'b0;
            n_re  = '0;
            n_im  = '0;
        end else begin
            n_sat = cl_re[W] | cl_im[W];
            n_re  = cl_re[W-1:0];
            n_im  = cl_im[W-1:0];
        end
    end

    // Output register: holds a result while the consumer stalls.
    logic r_out_v;
    logic signed [W-1:0] r_re, r_im;
    logic r_dz, r_eq, r_sat;

    assign ch_rdy[W] = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ch_rdy[W]) begin
            r_out_v <= ch_v[W];
        end
        if (ch_rdy[W]) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_dz  <= n_dz;
            r_eq  <= n_eq;
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_out_v;
    assign o_res_re    = IO_BITS'(r_re);
    assign o_res_im    = IO_BITS'(r_im);
    assign o_div_zero  = r_dz;
    assign o_equal     = r_eq;
    assign o_saturated = r_sat;

endmodule

/* design/cau_prep.sv */
// Front pipeline: operand capture, products, sums, final results for all but divide, and division setup.
module cau_prep #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32,
    parameter int SW        = 8 + 2 * WORD_BITS,
    parameter int NB        = 4 * WORD_BITS + 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [cau_pkg::CMD_BITS-1:0]   i_cmd,
    input  logic signed [cau_pkg::IO_BITS-1:0] i_lhs_re,
    input  logic signed [cau_pkg::IO_BITS-1:0] i_lhs_im,
    input  logic signed [cau_pkg::IO_BITS-1:0] i_rhs_re,
    input  logic signed [cau_pkg::IO_BITS-1:0] i_rhs_im,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [SW-1:0]                  o_side,
    output logic [NB-1:0]                  o_rem_re,
    output logic [NB-1:0]                  o_rem_im,
    output logic [2*WORD_BITS-1:0]         o_den
);
    import cau_pkg::*;

    localparam int W = WORD_BITS;
    localparam int P = 2 * W;
    localparam int X = P + 1;

    // Stage 1: operands.
    logic r_s1_v;
    logic [CMD_BITS-1:0] r_s1_cmd;
    logic signed [W-1:0] r_s1_a, r_s1_b, r_s1_c, r_s1_d;
    // Stage 2: products.
    logic r_s2_v;
    logic [CMD_BITS-1:0] r_s2_cmd;
    logic signed [W-1:0] r_s2_a, r_s2_b, r_s2_c, r_s2_d;
    logic signed [P-1:0] r_s2_ac, r_s2_bd, r_s2_bc, r_s2_ad, r_s2_cc, r_s2_dd;
    // Stage 3: sums.
    logic r_s3_v;
    logic [CMD_BITS-1:0] r_s3_cmd;
    logic signed [X-1:0] r_s3_x, r_s3_y;
    logic [P-1:0] r_s3_den;
    logic r_s3_eq;
    // Stage 4: results and division setup.
    logic r_s4_v;
    logic [SW-1:0] r_s4_side;
    logic [NB-1:0] r_s4_rem_re, r_s4_rem_im;
    logic [P-1:0] r_s4_den;

    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !r_s4_v || i_ready;
    assign rdy3 = !r_s3_v || rdy4;
    assign rdy2 = !r_s2_v || rdy3;
    assign rdy1 = !r_s1_v || rdy2;
    assign o_stall = !rdy1;

    // Clips a signed magnitude to the word range; returns {saturated, value}.
    function automatic logic [W:0] clip_fn(input logic neg, input logic [X-1:0] mag);
        logic [X-1:0] maxneg;
        logic [W:0] res;
        maxneg = X'(1) << (W - 1);
        if (neg) begin
            if (mag > maxneg) begin
                res = {1'b1, 1'b1, {(W-1){1'b0}}};
            end else begin
                res = {1'b0, W'(-mag)};
            end
        end else begin
            if (mag > maxneg - X'(1)) begin
                res = {1'b1, 1'b0, {(W-1){1'b1}}};
            end else begin
                res = {1'b0, mag[W-1:0]};
            end
        end
        return res;
    endfunction

    logic neg_x, neg_y;
    logic [X-1:0] mag_x, mag_y;
    logic [W:0] cl_x, cl_y;
    logic n_is_div, n_dz, n_eq, n_sat, n_ovf_x, n_ovf_y;
    logic [W-1:0] n_re, n_im;

    always_comb begin
        neg_x = r_s3_x[X-1];
        neg_y = r_s3_y[X-1];
        mag_x = neg_x ? X'(-r_s3_x) : X'(r_s3_x);
        mag_y = neg_y ? X'(-r_s3_y) : X'(r_s3_y);
        cl_x = clip_fn(neg_x, mag_x);
        cl_y = clip_fn(neg_y, mag_y);
        n_is_div = 1'b0;
        n_dz = 1'b0;
        n_eq = 1'b0;
        n_sat = 1'b0;
        n_re = '0;
        n_im = '0;
        n_ovf_x = ({NB'(mag_x)} << FRAC_BITS) >= ({NB'(r_s3_den)} << W);
        n_ovf_y = ({NB'(mag_y)} << FRAC_BITS) >= ({NB'(r_s3_den)} << W);
        unique case (r_s3_cmd)
            CMD_ADD, CMD_SUB: begin
                n_sat = cl_x[W] | cl_y[W];
                n_re = cl_x[W-1:0];
                n_im = cl_y[W-1:0];
            end
            CMD_MUL: begin
                cl_x = clip_fn(neg_x, mag_x >> FRAC_BITS);
                cl_y = clip_fn(neg_y, mag_y >> FRAC_BITS);
                n_sat = cl_x[W] | cl_y[W];
                n_re = cl_x[W-1:0];
                n_im = cl_y[W-1:0];
            end
            CMD_DIV: begin
                n_is_div = 1'b1;
                n_dz = (r_s3_den == '0);
            end
            CMD_CMP: begin
                n_eq = r_s3_eq;
            end
            default: begin
                n_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (rdy1) r_s1_v <= i_valid;
            if (rdy2) r_s2_v <= r_s1_v;
            if (rdy3) r_s3_v <= r_s2_v;
            if (rdy4) r_s4_v <= r_s3_v;
        end
        if (rdy1) begin
            r_s1_cmd <= i_cmd;
            r_s1_a <= i_lhs_re[W-1:0];
            r_s1_b <= i_lhs_im[W-1:0];
            r_s1_c <= i_rhs_re[W-1:0];
            r_s1_d <= i_rhs_im[W-1:0];
        end
        if (rdy2) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_a <= r_s1_a;
            r_s2_b <= r_s1_b;
            r_s2_c <= r_s1_c;
            r_s2_d <= r_s1_d;
            r_s2_ac <= r_s1_a * r_s1_c;
            r_s2_bd <= r_s1_b * r_s1_d;
            r_s2_bc <= r_s1_b * r_s1_c;
            r_s2_ad <= r_s1_a * r_s1_d;
            r_s2_cc <= r_s1_c * r_s1_c;
            r_s2_dd <= r_s1_d * r_s1_d;
        end
        if (rdy3) begin
            r_s3_cmd <= r_s2_cmd;
            r_s3_den <= $unsigned(r_s2_cc) + $unsigned(r_s2_dd);
            r_s3_eq <= (r_s2_a == r_s2_c) && (r_s2_b == r_s2_d);
            case (r_s2_cmd)
                CMD_ADD: begin
                    r_s3_x <= X'(r_s2_a) + X'(r_s2_c);
                    r_s3_y <= X'(r_s2_b) + X'(r_s2_d);
                end
                CMD_SUB: begin
                    r_s3_x <= X'(r_s2_a) - X'(r_s2_c);
                    r_s3_y <= X'(r_s2_b) - X'(r_s2_d);
                end
                CMD_MUL: begin
                    r_s3_x <= X'(r_s2_ac) - X'(r_s2_bd);
                    r_s3_y <= X'(r_s2_bc) + X'(r_s2_ad);
                end
                default: begin
                    r_s3_x <= X'(r_s2_ac) + X'(r_s2_bd);
                    r_s3_y <= X'(r_s2_bc) - X'(r_s2_ad);
                end
            endcase
        end
        if (rdy4) begin
            r_s4_side <= {n_is_div, n_dz, n_eq, n_sat, neg_x, neg_y, n_ovf_x, n_ovf_y,
                          n_re, n_im};
            r_s4_rem_re <= NB'(mag_x) << FRAC_BITS;
            r_s4_rem_im <= NB'(mag_y) << FRAC_BITS;
            r_s4_den <= r_s3_den;
        end
    end

    assign o_valid  = r_s4_v;
    assign o_side   = r_s4_side;
    assign o_rem_re = r_s4_rem_re;
    assign o_rem_im = r_s4_rem_im;
    assign o_den    = r_s4_den;

endmodule

/* design/cau_cell.sv */
// One divider cell: settles one quotient bit of both parts and passes the item on.
module cau_cell #(
    parameter int WORD_BITS = 32,
    parameter int BIT       = 0,
    parameter int SW        = 8 + 2 * WORD_BITS,
    parameter int NB        = 4 * WORD_BITS + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SW-1:0]          i_side,
    input  logic [NB-1:0]          i_rem_re,
    input  logic [NB-1:0]          i_rem_im,
    input  logic [2*WORD_BITS-1:0] i_den,
    input  logic [WORD_BITS-1:0]   i_q_re,
    input  logic [WORD_BITS-1:0]   i_q_im,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SW-1:0]          o_side,
    output logic [NB-1:0]          o_rem_re,
    output logic [NB-1:0]          o_rem_im,
    output logic [2*WORD_BITS-1:0] o_den,
    output logic [WORD_BITS-1:0]   o_q_re,
    output logic [WORD_BITS-1:0]   o_q_im
);
    import cau_pkg::*;

    localparam int W = WORD_BITS;

    logic r_v;
    logic [SW-1:0] r_side;
    logic [NB-1:0] r_rem_re, r_rem_im;
    logic [2*W-1:0] r_den;
    logic [W-1:0] r_q_re, r_q_im;

    logic [NB-1:0] dsh;
    logic ge_re, ge_im;

    assign o_ready = !r_v || i_ready;
    assign dsh   = NB'(i_den) << BIT;
    assign ge_re = i_rem_re >= dsh;
    assign ge_im = i_rem_im >= dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready) begin
            r_side   <= i_side;
            r_den    <= i_den;
            r_rem_re <= ge_re ? i_rem_re - dsh : i_rem_re;
            r_rem_im <= ge_im ? i_rem_im - dsh : i_rem_im;
            r_q_re   <= i_q_re | (W'(ge_re) << BIT);
            r_q_im   <= i_q_im | (W'(ge_im) << BIT);
        end
    end

    assign o_valid  = r_v;
    assign o_side   = r_side;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_den    = r_den;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;

endmodule
